### hdl/tdat_pkg.sv
// ----------------------------------------------------------------------------
// tdat_pkg
// Shared types, constants and helpers for the two-digit alarm timer.
// ----------------------------------------------------------------------------
package tdat_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int SET_W       = 8;

  localparam logic [SET_W-1:0] ALARM_RESET = 8'd99;
  localparam logic [SET_W-1:0] SPEED_RESET = 8'd2;
  localparam logic [3:0]       DIGIT_NINE  = 4'd9;
  localparam logic [7:0]       DOT_BIT     = 8'h80;

  // input transaction fields, highest bit first
  typedef struct packed {
    logic button;
    logic stop_switch;
    logic alarm_select;
    logic count_up;
    logic run_mode;
  } in_item_t;

  // result transaction fields, highest bit first
  typedef struct packed {
    logic       beep;
    logic       alarm_fire;
    logic [7:0] tens_segments;
    logic [6:0] units_segments;
    logic [3:0] tens_digit;
    logic [3:0] units_digit;
  } out_item_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digit_pair_t;

  function automatic logic [7:0] seg_lookup(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h77;
      4'h1: s = 8'h41;
      4'h2: s = 8'h3B;
      4'h3: s = 8'h6B;
      4'h4: s = 8'h4D;
      4'h5: s = 8'h6E;
      4'h6: s = 8'h7E;
      4'h7: s = 8'h43;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h6F;
      4'hA: s = 8'h5F;
      4'hB: s = 8'h7C;
      4'hC: s = 8'h36;
      4'hD: s = 8'h79;
      4'hE: s = 8'h3E;
      4'hF: s = 8'h1E;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // split an 8-bit value into decimal digits, quotient kept to 4 bits
  // reciprocal 205/2048 is exact for every 8-bit input
  function automatic digit_pair_t split_dec(input logic [7:0] x);
    logic [15:0]  prod;
    logic [4:0]   q;
    logic [7:0]   r;
    digit_pair_t  res;
    prod      = 16'(x) * 16'd205;
    q         = prod[15:11];
    r         = x - ({3'b000, q} * 8'd10);
    res.tens  = q[3:0];
    res.units = r[3:0];
    return res;
  endfunction

endpackage

### hdl/two_digit_alarm_timer_unit.sv
// ----------------------------------------------------------------------------
// two_digit_alarm_timer_unit
// Two-digit up/down alarm timer driven by display-scan ticks.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (lowest bit first)
//  in_     | in  | run_mode, count_up, alarm_select, stop_switch, button
//  out_    | out | units_digit, tens_digit, units_segments, tens_segments,
//          |     | alarm_fire, beep
//
//  one transaction per cycle sustained while out_tready allows; each result passes
//  the input register, then the result register; state updates with the result
//  rst_n clears the pipeline valids and loads the timer state defaults
//  a stalled result holds; one further tick is held in the input register
// ----------------------------------------------------------------------------
module two_digit_alarm_timer_unit #(
  parameter int SCANS_PER_UNIT = 10,
  parameter int SETTING_LIMIT  = 159
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // run_mode, count_up, alarm_select, stop_switch, button, zero pad
  input  logic [tdat_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // units_digit[3:0], tens_digit[7:4], units_segments[14:8],
  // tens_segments[22:15], alarm_fire[23], beep[24], zero pad
  output logic [tdat_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import tdat_pkg::*;

  localparam int SCAN_W = $clog2(SCANS_PER_UNIT * SETTING_LIMIT + 1);
  localparam logic [SET_W-1:0] SET_LIM = SET_W'(SETTING_LIMIT);

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic              advance;

  logic [3:0]        units_r, units_nxt;
  logic [3:0]        tens_r, tens_nxt;
  logic [3:0]        lim_units_r, lim_units_nxt;
  logic [3:0]        lim_tens_r, lim_tens_nxt;
  logic [SET_W-1:0]  alarm_r, alarm_nxt;
  logic [SET_W-1:0]  speed_r, speed_nxt;
  logic              paused_r, paused_nxt;
  logic              toggle_r, toggle_nxt;
  logic              set_mode_r, set_mode_nxt;
  logic [SCAN_W-1:0] scans_r, scans_nxt;
  out_item_t         result;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_item_r);

  always_comb begin
    logic [4:0]        u5, t5;
    logic [SCAN_W-1:0] scans;
    logic [SET_W-1:0]  inc;
    logic              fire, beep;
    digit_pair_t       dp;
    logic [7:0]        tseg;
    logic [7:0]        useg;

    units_nxt     = units_r;
    tens_nxt      = tens_r;
    lim_units_nxt = lim_units_r;
    lim_tens_nxt  = lim_tens_r;
    alarm_nxt     = alarm_r;
    speed_nxt     = speed_r;
    paused_nxt    = paused_r;
    toggle_nxt    = toggle_r;
    set_mode_nxt  = set_mode_r;
    fire          = 1'b0;
    beep          = 1'b0;
    scans         = scans_r;
    u5            = '0;
    t5            = '0;
    inc           = '0;
    dp            = '0;

    // count step when the scan countdown has run out
    if (scans_r == '0) begin
      if (s1_item_r.run_mode) begin
        if (!paused_r) begin
          if (s1_item_r.count_up) begin
            u5 = {1'b0, units_r} + 5'd1;
            t5 = {1'b0, tens_r};
            if (u5 > 5'd9) begin
              u5 = '0;
              t5 = t5 + 5'd1;
              if (t5 > {1'b0, lim_tens_r}) t5 = '0;
            end
            if (t5 >= {1'b0, lim_tens_r} && u5 > {1'b0, lim_units_r}) begin
              u5 = '0;
              t5 = '0;
            end
            units_nxt = u5[3:0];
            tens_nxt  = t5[3:0];
          end else if (units_r == '0) begin
            units_nxt = DIGIT_NINE;
            tens_nxt  = (tens_r == '0) ? lim_tens_r : tens_r - 4'd1;
          end else begin
            units_nxt = units_r - 4'd1;
          end
        end
        fire = (units_nxt == lim_units_r) && (tens_nxt == lim_tens_r) &&
               !s1_item_r.alarm_select;
      end
      scans = SCAN_W'(SCAN_W'(SCANS_PER_UNIT) * SCAN_W'(speed_r));
    end
    scans_nxt = (scans != '0) ? scans - SCAN_W'(1) : scans;

    // button and mode handling
    if (s1_item_r.run_mode) begin
      if (set_mode_r) begin
        set_mode_nxt = 1'b0;
        units_nxt    = '0;
        tens_nxt     = '0;
        paused_nxt   = 1'b0;
      end
      if (s1_item_r.stop_switch) begin
        paused_nxt = 1'b1;
        toggle_nxt = 1'b0;
      end else begin
        if (s1_item_r.button) begin
          beep       = 1'b1;
          toggle_nxt = !toggle_r;
        end
        paused_nxt = toggle_nxt;
      end
    end else begin
      if (!set_mode_r) begin
        set_mode_nxt = 1'b1;
        paused_nxt   = 1'b1;
      end
      if (!s1_item_r.alarm_select) begin
        if (s1_item_r.button) begin
          beep      = 1'b1;
          inc       = alarm_r + SET_W'(1);
          alarm_nxt = (inc > SET_LIM) ? '0 : inc;
        end
        dp            = split_dec(alarm_nxt);
        lim_units_nxt = dp.units;
        lim_tens_nxt  = dp.tens;
      end else begin
        if (s1_item_r.button) begin
          beep      = 1'b1;
          inc       = speed_r + SET_W'(1);
          speed_nxt = (inc > SET_LIM) ? SET_W'(1) : inc;
        end
        dp = split_dec(speed_nxt);
      end
      units_nxt = dp.units;
      tens_nxt  = dp.tens;
    end

    tseg = seg_lookup(tens_nxt);
    if (!s1_item_r.run_mode && s1_item_r.alarm_select) tseg = tseg | DOT_BIT;
    useg = seg_lookup(units_nxt);

    result.units_digit    = units_nxt;
    result.tens_digit     = tens_nxt;
    result.units_segments = useg[6:0];
    result.tens_segments  = tseg;
    result.alarm_fire     = fire;
    result.beep           = beep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      units_r     <= '0;
      tens_r      <= '0;
      lim_units_r <= DIGIT_NINE;
      lim_tens_r  <= DIGIT_NINE;
      alarm_r     <= ALARM_RESET;
      speed_r     <= SPEED_RESET;
      paused_r    <= 1'b0;
      toggle_r    <= 1'b0;
      set_mode_r  <= 1'b0;
      scans_r     <= '0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        units_r     <= units_nxt;
        tens_r      <= tens_nxt;
        lim_units_r <= lim_units_nxt;
        lim_tens_r  <= lim_tens_nxt;
        alarm_r     <= alarm_nxt;
        speed_r     <= speed_nxt;
        paused_r    <= paused_nxt;
        toggle_r    <= toggle_nxt;
        set_mode_r  <= set_mode_nxt;
        scans_r     <= scans_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_item_r <= in_item_t'(in_tdata[4:0]);
    if (advance) out_item_r <= result;
  end

endmodule

### hdl/tdat_chk.sv
// ----------------------------------------------------------------------------
// tdat_chk
// Port-level checks for the two-digit alarm timer, bound to the top level.
// ----------------------------------------------------------------------------
module tdat_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tdat_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tdat_pkg::*;

  out_item_t res;
  assign res = out_item_t'(out_tdata[$bits(out_item_t)-1:0]);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the units digit never leaves decimal range
  a_units_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.units_digit <= 4'd9)
    else $error("units digit out of range");

  // speed edit dot means set mode, where the alarm cannot fire
  a_dot_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.tens_segments[7] |-> !res.alarm_fire)
    else $error("alarm fired while editing speed");

  // the input side is never refused while the pipeline has room
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(!in_tvalid) && $past(rst_n) |-> in_tready)
    else $error("input refused with empty pipeline");

endmodule

bind two_digit_alarm_timer_unit tdat_chk u_tdat_chk (.*);

### tb/two_digit_alarm_timer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_digit_alarm_timer_unit_test
// Self-checking bench for the alarm timer: scan ticks go in on the in_ stream,
// every display transaction on the out_ stream is checked against a tick-level
// model of the counter, settings editor, pause logic and segment decode.
// ----------------------------------------------------------------------------
module two_digit_alarm_timer_unit_test;
  import tdat_pkg::*;

  localparam int SCAN_STEP      = 10;
  localparam int SETTING_MAX    = 159;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  localparam logic [7:0] SEG_PATTERN [16] = '{
    8'h77, 8'h41, 8'h3B, 8'h6B, 8'h4D, 8'h6E, 8'h7E, 8'h43,
    8'h7F, 8'h6F, 8'h5F, 8'h7C, 8'h36, 8'h79, 8'h3E, 8'h1E
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // timer model state
  logic [3:0]  cnt_units, cnt_tens, wrap_units, wrap_tens;
  logic [7:0]  alarm_val, speed_val;
  bit          halted, halt_toggle, editing;
  int unsigned scan_count;

  out_item_t   display_queue[$];
  int unsigned mismatches;
  int unsigned ticks_sent;
  int unsigned displays_checked;
  int unsigned fires_seen;
  int unsigned beeps_seen;
  int unsigned ready_hold;
  int unsigned idle_cycles;
  bit          in_burst, out_burst;

  two_digit_alarm_timer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic in_item_t tick_of(input bit run, input bit up, input bit sel,
                                       input bit stop, input bit btn);
    in_item_t it;
    it.run_mode     = run;
    it.count_up     = up;
    it.alarm_select = sel;
    it.stop_switch  = stop;
    it.button       = btn;
    return it;
  endfunction

  task automatic reset_timer_model();
    cnt_units   = 4'd0;
    cnt_tens    = 4'd0;
    wrap_units  = 4'd9;
    wrap_tens   = 4'd9;
    alarm_val   = 8'd99;
    speed_val   = 8'd2;
    halted      = 1'b0;
    halt_toggle = 1'b0;
    editing     = 1'b0;
    scan_count  = 0;
  endtask

  // one scan tick through the model, expected display queued
  task automatic predict_display(input in_item_t it);
    out_item_t res;
    int        u, t;
    bit        fire, beep;
    fire = 1'b0;
    beep = 1'b0;
    if (scan_count == 0) begin
      if (it.run_mode) begin
        if (!halted) begin
          if (it.count_up) begin
            u = cnt_units + 1;
            t = cnt_tens;
            if (u > 9) begin
              u = 0;
              t = t + 1;
              if (t > wrap_tens) t = 0;
            end
            if (t >= wrap_tens && u > wrap_units) begin
              u = 0;
              t = 0;
            end
            cnt_units = u[3:0];
            cnt_tens  = t[3:0];
          end else if (cnt_units == 4'd0) begin
            cnt_units = 4'd9;
            cnt_tens  = (cnt_tens == 4'd0) ? wrap_tens : cnt_tens - 4'd1;
          end else begin
            cnt_units = cnt_units - 4'd1;
          end
        end
        fire = (cnt_units == wrap_units) && (cnt_tens == wrap_tens) && !it.alarm_select;
      end
      scan_count = SCAN_STEP * speed_val;
    end
    if (scan_count != 0) scan_count--;

    if (it.run_mode) begin
      if (editing) begin
        editing   = 1'b0;
        cnt_units = 4'd0;
        cnt_tens  = 4'd0;
        halted    = 1'b0;
      end
      if (it.stop_switch) begin
        halted      = 1'b1;
        halt_toggle = 1'b0;
      end else begin
        if (it.button) begin
          beep        = 1'b1;
          halt_toggle = !halt_toggle;
        end
        halted = halt_toggle;
      end
    end else begin
      if (!editing) begin
        editing = 1'b1;
        halted  = 1'b1;
      end
      if (!it.alarm_select) begin
        if (it.button) begin
          beep      = 1'b1;
          alarm_val = alarm_val + 8'd1;
          if (alarm_val > SETTING_MAX) alarm_val = 8'd0;
        end
        wrap_units = 4'(alarm_val % 10);
        wrap_tens  = 4'(alarm_val / 10);
        cnt_units  = wrap_units;
        cnt_tens   = wrap_tens;
      end else begin
        if (it.button) begin
          beep      = 1'b1;
          speed_val = speed_val + 8'd1;
          if (speed_val > SETTING_MAX) speed_val = 8'd1;
        end
        cnt_units = 4'(speed_val % 10);
        cnt_tens  = 4'(speed_val / 10);
      end
    end

    res.units_digit    = cnt_units;
    res.tens_digit     = cnt_tens;
    res.units_segments = SEG_PATTERN[cnt_units][6:0];
    res.tens_segments  = SEG_PATTERN[cnt_tens] |
                         ((!it.run_mode && it.alarm_select) ? DOT_BIT : 8'h00);
    res.alarm_fire     = fire;
    res.beep           = beep;
    display_queue.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at display %0d: %s got 0x%0h expected 0x%0h",
             displays_checked, what, got, want);
    mismatches++;
  endtask

  task automatic check_display(input out_item_t got);
    out_item_t want;
    if (got.alarm_fire) fires_seen++;
    if (got.beep) beeps_seen++;
    if (display_queue.size() == 0) begin
      report_mismatch("unexpected display", got, 0);
    end else begin
      want = display_queue.pop_front();
      if (got.units_digit != want.units_digit)
        report_mismatch("units_digit", got.units_digit, want.units_digit);
      if (got.tens_digit != want.tens_digit)
        report_mismatch("tens_digit", got.tens_digit, want.tens_digit);
      if (got.units_segments != want.units_segments)
        report_mismatch("units_segments", got.units_segments, want.units_segments);
      if (got.tens_segments != want.tens_segments)
        report_mismatch("tens_segments", got.tens_segments, want.tens_segments);
      if (got.alarm_fire != want.alarm_fire)
        report_mismatch("alarm_fire", got.alarm_fire, want.alarm_fire);
      if (got.beep != want.beep)
        report_mismatch("beep", got.beep, want.beep);
    end
    displays_checked++;
  endtask

  // valid is only lowered when a gap is drawn, never dropped and re-raised in one step
  task automatic send_tick(input in_item_t it);
    int unsigned           gap;
    logic [IN_TDATA_W-1:0] word;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    word = '0;
    word[$bits(in_item_t)-1:0] = it;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_display(it);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (display_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int i;
    in_burst  = 1'b0;
    out_burst = 1'b0;
    send_tick(tick_of(1, 1, 0, 0, 0));  // first tick runs a count step
    send_tick(tick_of(1, 1, 0, 0, 0));
    send_tick(tick_of(1, 1, 0, 1, 1));  // stop switch swallows the button
    send_tick(tick_of(1, 1, 0, 0, 1));  // pause toggle
    send_tick(tick_of(1, 1, 0, 0, 1));
    send_tick(tick_of(1, 0, 1, 0, 0));
    send_tick(tick_of(0, 0, 0, 0, 0));  // into set mode, alarm shown
    send_tick(tick_of(0, 0, 0, 0, 1));  // alarm 100, tens digit above nine
    send_tick(tick_of(0, 0, 1, 0, 0));  // speed shown with the dot
    send_tick(tick_of(0, 0, 1, 0, 1));
    send_tick(tick_of(0, 1, 1, 1, 1));
    send_tick(tick_of(1, 1, 0, 0, 0));  // leaving set mode clears the count
    send_tick(tick_of(1, 1, 1, 1, 1));
    send_tick(tick_of(0, 0, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 0, 0));
    in_burst = 1'b1;
    for (i = 0; i < 9; i++) send_tick(tick_of(1, 0, 0, 0, 0));
  endtask

  task automatic test_setting_wrap();
    in_burst  = 1'b0;
    out_burst = 1'b1;
    do send_tick(tick_of(0, 0, 0, 0, 1)); while (alarm_val != 8'd0);
    in_burst  = 1'b1;
    out_burst = 1'b0;
    do send_tick(tick_of(0, 1, 1, 0, 1)); while (speed_val != 8'd1);
    wait_drained();
  endtask

  task automatic test_alarm_extremes();
    int i;
    // alarm at zero: every count-up step lands on the alarm
    in_burst = 1'b1;
    for (i = 0; i < 35; i++) send_tick(tick_of(1, 1, 0, 0, 0));
    for (i = 0; i < 35; i++) send_tick(tick_of(1, 0, 0, 0, 0));
    in_burst = 1'b0;
    while (alarm_val != SETTING_MAX) send_tick(tick_of(0, 0, 0, 0, 1));
    // alarm at the top: count down goes through hex tens digits
    for (i = 0; i < 120; i++) send_tick(tick_of(1, 0, 0, 0, 0));
    for (i = 0; i < 40; i++) send_tick(tick_of(1, 1, (i >= 20), 0, 0));
  endtask

  task automatic test_random_episodes(input int target);
    int          sent, len, len_max, i;
    int unsigned kind;
    bit          up, sel;
    in_item_t    it;
    sent = 0;
    while (sent < target) begin
      kind      = $urandom_range(0, 99);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      up        = $urandom_range(0, 1);
      sel       = $urandom_range(0, 1);
      if (kind < 50) begin
        // counting stretch sized from the speed setting, at most 305 ticks
        len_max = 25 * speed_val;
        if (len_max > 300) len_max = 300;
        len = $urandom_range(len_max + 5, 5);
        if ($urandom_range(0, 4) != 0) sel = 1'b0;
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 49) == 0) up = !up;
          send_tick(tick_of(1, up, sel, ($urandom_range(0, 19) == 0),
                            ($urandom_range(0, 24) == 0)));
        end
      end else if (kind < 85) begin
        // editing stretch; speed presses kept rare so counting stays brisk
        len = $urandom_range(30, 1);
        for (i = 0; i < len; i++)
          send_tick(tick_of(0, $urandom_range(0, 1), sel, $urandom_range(0, 1),
                            sel ? ($urandom_range(0, 19) == 0) : $urandom_range(0, 1)));
      end else begin
        len = $urandom_range(8, 1);
        for (i = 0; i < len; i++) begin
          it = in_item_t'(5'($urandom_range(31, 0)));
          send_tick(it);
        end
      end
      sent += len;
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
  endtask

  // receiver stalls drawn after every accepted display unless out_burst is set
  always @(posedge clk) begin : display_sink
    int unsigned hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      check_display(out_item_t'(out_tdata[$bits(out_item_t)-1:0]));
      hold = out_burst ? 0 : $urandom_range(0, 19);
      ready_hold <= hold;
      out_tready <= (hold == 0);
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= (ready_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("two_digit_alarm_timer_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_burst         = 1'b0;
    out_burst        = 1'b0;
    mismatches       = 0;
    ticks_sent       = 0;
    displays_checked = 0;
    fires_seen       = 0;
    beeps_seen       = 0;
    reset_timer_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_drained();
    test_setting_wrap();
    test_alarm_extremes();
    test_random_episodes(600);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (display_queue.size() != 0)
      report_mismatch("displays never delivered", display_queue.size(), 0);

    $display("ran %0d scan ticks, checked %0d displays (%0d alarm pulses, %0d beeps)",
             ticks_sent, displays_checked, fires_seen, beeps_seen);
    $display("both setting wraps, alarm at 0 and 159, stop/pause and mode changes; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("two_digit_alarm_timer_unit regression: pass");
    end else begin
      $display("two_digit_alarm_timer_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tdat_pkg.sv
hdl/two_digit_alarm_timer_unit.sv
hdl/tdat_chk.sv
tb/two_digit_alarm_timer_unit_test.sv
